>>> sv/selective_repeat_receiver_assert.svh
// Assertion macros for the selective-repeat receiver.
// Used by srr_ctrl under sv/; expects clk_i and rst_ni in scope.
`ifndef SELECTIVE_REPEAT_RECEIVER_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVER_ASSERT_SVH
`ifndef SYNTHESIS
// checked outside reset only
`define SRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked on every edge, reset included
`define SRR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SRR_ASSERT(lbl, prop, msg)
`define SRR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> sv/srr_pkg.sv
// Shared types, constants and helpers of the selective-repeat receiver.
// No dependencies; imported by every module of the block.
package srr_pkg;

  localparam int WINDOW_MAX    = 32;
  localparam int PAYLOAD_BYTES = 20;
  localparam int SLOT_W        = $clog2(WINDOW_MAX);
  localparam int WIN_W         = 6;
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(8);
  localparam int PSUM_W        = 11;  // sum of 8 signed bytes
  localparam int CSUM_W        = PSUM_W + 2;  // sum of three partial sums

  typedef enum logic {
    KIND_ACK  = 1'b0,
    KIND_DATA = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_CHECK,
    S_DELIVER,
    S_ACK,
    S_DRAIN
  } state_e;

  typedef struct packed {
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [31:0] checksum_in;
    logic [63:0] payload_lo;
    logic [63:0] payload_mid;
    logic [31:0] payload_hi;
  } packet_t;

  typedef struct packed {
    kind_e       kind;
    logic        last;
    logic [31:0] ack_value;
    logic [63:0] out_lo;
    logic [63:0] out_mid;
    logic [31:0] out_hi;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] lo;
    logic [63:0] mid;
    logic [31:0] hi;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic wr;
  } cell_ctrl_t;

  typedef struct packed {
    logic              shift;
    logic              wr;
    logic [SLOT_W-1:0] wr_idx;
  } chain_ctrl_t;

  // bytes of a word starting at payload byte "first" that belong to the payload
  function automatic logic [63:0] keep_mask(int first, int count);
    logic [63:0] m;
    m = '0;
    for (int k = 0; k < count; k++) begin
      if (first + k < PAYLOAD_BYTES) m[8*k +: 8] = 8'hFF;
    end
    return m;
  endfunction

  localparam logic [63:0] MASK_LO  = keep_mask(0, 8);
  localparam logic [63:0] MASK_MID = keep_mask(8, 8);
  localparam logic [31:0] MASK_HI  = 32'(keep_mask(16, 4));

  // sum of eight sign-extended bytes
  function automatic logic signed [PSUM_W-1:0] byte_sum(logic [63:0] w);
    logic signed [PSUM_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      acc = acc + $signed({{(PSUM_W-8){w[8*k+7]}}, w[8*k +: 8]});
    end
    return acc;
  endfunction

endpackage

>>> sv/srr_cell.sv
// One reorder cell: holds the packet at a fixed offset from the receive base.
// Depends on srr_pkg. Shifts toward the head when the base advances.
module srr_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srr_pkg::cell_ctrl_t ctrl_i,
  input  srr_pkg::slot_t     nbr_i,
  input  srr_pkg::slot_t     wr_i,
  output srr_pkg::slot_t     slot_o
);
  import srr_pkg::*;

  logic        valid_q, valid_d;
  logic [63:0] lo_q, mid_q;
  logic [31:0] hi_q;

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      valid_d = nbr_i.valid;
    end else if (ctrl_i.wr) begin
      valid_d = wr_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload needs no reset, a slot is read only while valid
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      lo_q  <= nbr_i.lo;
      mid_q <= nbr_i.mid;
      hi_q  <= nbr_i.hi;
    end else if (ctrl_i.wr) begin
      lo_q  <= wr_i.lo;
      mid_q <= wr_i.mid;
      hi_q  <= wr_i.hi;
    end
  end

  assign slot_o = '{valid: valid_q, lo: lo_q, mid: mid_q, hi: hi_q};

endmodule

>>> sv/srr_ctrl.sv
// Sequencer of the selective-repeat receiver: checksum, window test,
// receive base, result register. Depends on srr_pkg and the assert header.
`include "selective_repeat_receiver_assert.svh"

module srr_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [srr_pkg::WIN_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  srr_pkg::packet_t              in_pkt_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output srr_pkg::result_t              out_res_o,
  output srr_pkg::chain_ctrl_t          chain_o,
  output srr_pkg::slot_t                wr_slot_o,
  input  srr_pkg::slot_t                head_i,
  input  logic                          next_valid_i
);
  import srr_pkg::*;

  state_e                   state_q, state_d;
  logic [WIN_W-1:0]         win_size_q;
  logic [31:0]              base_q, base_d;
  packet_t                  pkt_q;
  logic signed [PSUM_W-1:0] psum_lo_q, psum_mid_q, psum_hi_q;
  logic [31:0]              seqack_q, off_q;
  logic                     out_valid_q, out_valid_d;
  result_t                  out_res_q, res_d;

  logic signed [CSUM_W-1:0] csum;
  logic [31:0]              total;
  logic [WIN_W-1:0]         win_eff;
  logic                     ok, off_zero, in_win, can_load, emit;

  assign csum = CSUM_W'(psum_lo_q) + CSUM_W'(psum_mid_q) + CSUM_W'(psum_hi_q);
  assign total = seqack_q + {{(32-CSUM_W){csum[CSUM_W-1]}}, csum};
  assign ok = (total == pkt_q.checksum_in);
  assign win_eff = (win_size_q > WIN_W'(WINDOW_MAX)) ? WIN_W'(WINDOW_MAX) : win_size_q;
  assign off_zero = (off_q == 32'd0);
  assign in_win = (off_q < {{(32-WIN_W){1'b0}}, win_eff});
  assign can_load = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (in_valid_i) state_d = S_SUM;
      S_SUM:     state_d = S_CHECK;
      S_CHECK: begin
        if (!ok) state_d = S_IDLE;
        else if (off_zero) state_d = S_DELIVER;
        else state_d = S_ACK;
      end
      S_DELIVER: if (can_load) state_d = S_ACK;
      S_ACK: begin
        if (can_load) state_d = head_i.valid ? S_DRAIN : S_IDLE;
      end
      S_DRAIN:   if (can_load && !next_valid_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o     = 1'b0;
    emit           = 1'b0;
    res_d          = '0;
    chain_o.shift  = 1'b0;
    chain_o.wr     = 1'b0;
    chain_o.wr_idx = off_q[SLOT_W-1:0];
    case (state_q)
      S_IDLE:  in_ready_o = 1'b1;
      S_CHECK: chain_o.wr = ok && !off_zero && in_win;
      S_DELIVER: begin
        emit          = can_load;
        chain_o.shift = can_load;
        res_d.kind    = KIND_DATA;
        res_d.out_lo  = pkt_q.payload_lo;
        res_d.out_mid = pkt_q.payload_mid;
        res_d.out_hi  = pkt_q.payload_hi;
      end
      S_ACK: begin
        emit            = can_load;
        res_d.kind      = KIND_ACK;
        res_d.ack_value = pkt_q.seq_num;
        res_d.last      = !head_i.valid;
      end
      S_DRAIN: begin
        emit          = can_load;
        chain_o.shift = can_load;
        res_d.kind    = KIND_DATA;
        res_d.out_lo  = head_i.lo;
        res_d.out_mid = head_i.mid;
        res_d.out_hi  = head_i.hi;
        res_d.last    = !next_valid_i;
      end
      default: ;
    endcase
  end

  assign wr_slot_o = '{valid: 1'b1, lo: pkt_q.payload_lo, mid: pkt_q.payload_mid,
                       hi: pkt_q.payload_hi};

  assign base_d = base_q + {31'd0, chain_o.shift};
  assign out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_size_q  <= WIN_RESET;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) win_size_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      pkt_q.seq_num     <= in_pkt_i.seq_num;
      pkt_q.ack_num     <= in_pkt_i.ack_num;
      pkt_q.checksum_in <= in_pkt_i.checksum_in;
      pkt_q.payload_lo  <= in_pkt_i.payload_lo & MASK_LO;
      pkt_q.payload_mid <= in_pkt_i.payload_mid & MASK_MID;
      pkt_q.payload_hi  <= in_pkt_i.payload_hi & MASK_HI;
    end
    if (state_q == S_SUM) begin
      psum_lo_q  <= byte_sum(pkt_q.payload_lo);
      psum_mid_q <= byte_sum(pkt_q.payload_mid);
      psum_hi_q  <= byte_sum({32'd0, pkt_q.payload_hi});
      seqack_q   <= pkt_q.seq_num + pkt_q.ack_num;
      off_q      <= pkt_q.seq_num - base_q;
    end
    if (emit) out_res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  `SRR_ASSERT_ALWAYS(a_no_shift_and_store, !(chain_o.shift && chain_o.wr), "shift during store")
  `SRR_ASSERT(a_head_empty_idle, state_q == S_IDLE |-> !head_i.valid, "head cell valid at rest")
  `SRR_ASSERT(a_store_not_head, chain_o.wr |-> chain_o.wr_idx != '0, "store into head cell")
  `SRR_ASSERT(a_base_advance, chain_o.shift |=> base_q == $past(base_q) + 32'd1, "base not advanced")

endmodule

>>> sv/selective_repeat_receiver.sv
// Selective-repeat receiver. A packet is accepted only while the block is idle; the checksum and
// window test run in the S_SUM and S_CHECK states, then the results the packet causes follow one
// by one (no result for a bad checksum, otherwise 1 to 33), each held back while the output is
// stalled; the next packet is taken only after its last result enters the single result register.
// The row of reorder cells moves one place toward the head per delivery. Cell k holds the packet
// at offset k from the receive base; reset clears the valid bits at once, with no clearing pass.
module selective_repeat_receiver (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [srr_pkg::WIN_W-1:0] cfg_wdata_i,    // window_size
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // seq_num, ack_num, checksum_in, payload_lo, payload_mid, payload_hi
  input  logic [255:0]              s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // ack_value, ack_sum, out_lo, out_mid, out_hi
  output logic [223:0]              m_axis_tdata_o,
  output logic [0:0]                m_axis_tuser_o, // kind
  output logic                      m_axis_tlast_o
);
  import srr_pkg::*;

  packet_t     in_pkt;
  result_t     out_res;
  chain_ctrl_t chain;
  slot_t       wr_slot;
  slot_t       cells [WINDOW_MAX];
  slot_t       nbrs  [WINDOW_MAX];

  assign in_pkt.seq_num     = s_axis_tdata_i[31:0];
  assign in_pkt.ack_num     = s_axis_tdata_i[63:32];
  assign in_pkt.checksum_in = s_axis_tdata_i[95:64];
  assign in_pkt.payload_lo  = s_axis_tdata_i[159:96];
  assign in_pkt.payload_mid = s_axis_tdata_i[223:160];
  assign in_pkt.payload_hi  = s_axis_tdata_i[255:224];

  srr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_pkt_i     (in_pkt),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_res_o    (out_res),
    .chain_o      (chain),
    .wr_slot_o    (wr_slot),
    .head_i       (cells[0]),
    .next_valid_i (cells[1].valid)
  );

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    cell_ctrl_t cctrl;
    assign cctrl.shift = chain.shift;
    assign cctrl.wr    = chain.wr && (chain.wr_idx == SLOT_W'(i));
    if (i == WINDOW_MAX - 1) begin : g_tail
      assign nbrs[i] = '0;
    end else begin : g_mid
      assign nbrs[i] = cells[i+1];
    end
    srr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cctrl),
      .nbr_i  (nbrs[i]),
      .wr_i   (wr_slot),
      .slot_o (cells[i])
    );
  end

  assign m_axis_tdata_o = {out_res.out_hi, out_res.out_mid, out_res.out_lo,
                           out_res.ack_value, out_res.ack_value};
  assign m_axis_tuser_o = out_res.kind;
  assign m_axis_tlast_o = out_res.last;

endmodule

>>> test/srr_delivery_checker.sv
// Checker for the selective-repeat receiver: tracks receive base, window and reorder store.
// Predicts the results of every accepted packet and compares the result stream against them.
// Depends on srr_pkg for the result kind, the store depth and the payload masks.
module srr_delivery_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [srr_pkg::WIN_W-1:0] cfg_wdata_i,
  input  logic                      pkt_valid_i,
  input  logic                      pkt_ready_i,
  input  logic [255:0]              pkt_data_i,
  input  logic                      res_valid_i,
  input  logic                      res_ready_i,
  input  logic [223:0]              res_data_i,
  input  logic [0:0]                res_kind_i,
  input  logic                      res_last_i,
  output int                        mismatch_o,
  output int                        pending_o
);

  typedef struct {
    srr_pkg::kind_e kind;
    logic [31:0]    ack_value;
    logic [31:0]    ack_sum;
    logic [63:0]    lo;
    logic [63:0]    mid;
    logic [31:0]    hi;
    logic           last;
  } delivery_t;

  delivery_t                 due_results[$];
  delivery_t                 want;
  logic [srr_pkg::WIN_W-1:0] window;
  logic [31:0]               rx_base;
  logic                      held     [srr_pkg::WINDOW_MAX];
  logic [63:0]               held_lo  [srr_pkg::WINDOW_MAX];
  logic [63:0]               held_mid [srr_pkg::WINDOW_MAX];
  logic [31:0]               held_hi  [srr_pkg::WINDOW_MAX];
  int                        mismatches   = 0;
  int                        results_seen = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want_val);
    if (mismatches < 40)
      $display("checker: result %0d %s got %h expected %h", results_seen, what, got, want_val);
    mismatches++;
  endtask

  function automatic void queue_result(srr_pkg::kind_e kind, logic [31:0] av,
                                       logic [63:0] lo, logic [63:0] mid, logic [31:0] hi);
    delivery_t r;
    r.kind      = kind;
    r.ack_value = av;
    r.ack_sum   = av;
    r.lo        = lo;
    r.mid       = mid;
    r.hi        = hi;
    r.last      = 1'b0;
    due_results.insert(due_results.size(), r);
  endfunction

  // works out what one accepted packet causes and updates the store
  task automatic reorder_packet(input logic [255:0] w);
    logic [31:0] seq, ackn, csum, sum, off, win;
    logic [63:0] lo, mid;
    logic [31:0] hi;
    int          slot;
    seq  = w[31:0];
    ackn = w[63:32];
    csum = w[95:64];
    lo   = w[159:96] & srr_pkg::MASK_LO;
    mid  = w[223:160] & srr_pkg::MASK_MID;
    hi   = w[255:224] & srr_pkg::MASK_HI;
    sum  = seq + ackn;
    for (int k = 0; k < 8; k++) begin
      sum = sum + {{24{lo[8*k+7]}}, lo[8*k +: 8]};
      sum = sum + {{24{mid[8*k+7]}}, mid[8*k +: 8]};
    end
    for (int k = 0; k < 4; k++) sum = sum + {{24{hi[8*k+7]}}, hi[8*k +: 8]};
    if (sum != csum) return;

    win = (window > srr_pkg::WINDOW_MAX) ? srr_pkg::WINDOW_MAX : window;
    off = seq - rx_base;
    if (off == 32'd0) begin
      queue_result(srr_pkg::KIND_DATA, 32'd0, lo, mid, hi);
      rx_base = rx_base + 32'd1;
    end else if (off < win) begin
      slot           = seq % srr_pkg::WINDOW_MAX;
      held[slot]     = 1'b1;
      held_lo[slot]  = lo;
      held_mid[slot] = mid;
      held_hi[slot]  = hi;
    end
    queue_result(srr_pkg::KIND_ACK, seq, 64'd0, 64'd0, 32'd0);

    // drain whatever is now in order
    for (int i = 0; i + 1 < srr_pkg::WINDOW_MAX; i++) begin
      slot = rx_base % srr_pkg::WINDOW_MAX;
      if (!held[slot]) break;
      queue_result(srr_pkg::KIND_DATA, 32'd0, held_lo[slot], held_mid[slot], held_hi[slot]);
      held[slot] = 1'b0;
      rx_base    = rx_base + 32'd1;
    end
    due_results[due_results.size()-1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window  = srr_pkg::WIN_RESET;
      rx_base = 32'd0;
      foreach (held[i]) held[i] = 1'b0;
      due_results.delete();
    end else begin
      if (res_valid_i && res_ready_i) begin
        results_seen++;
        if (due_results.size() == 0) begin
          report_mismatch("unexpected", res_data_i[63:0], 64'd0);
        end else begin
          want = due_results.pop_front();
          if (res_kind_i[0] !== want.kind)
            report_mismatch("kind", {63'd0, res_kind_i[0]}, {63'd0, want.kind});
          if (res_data_i[31:0] !== want.ack_value)
            report_mismatch("ack_value", {32'd0, res_data_i[31:0]}, {32'd0, want.ack_value});
          if (res_data_i[63:32] !== want.ack_sum)
            report_mismatch("ack_sum", {32'd0, res_data_i[63:32]}, {32'd0, want.ack_sum});
          if (res_data_i[127:64] !== want.lo)
            report_mismatch("out_lo", res_data_i[127:64], want.lo);
          if (res_data_i[191:128] !== want.mid)
            report_mismatch("out_mid", res_data_i[191:128], want.mid);
          if (res_data_i[223:192] !== want.hi)
            report_mismatch("out_hi", {32'd0, res_data_i[223:192]}, {32'd0, want.hi});
          if (res_last_i !== want.last)
            report_mismatch("last", {63'd0, res_last_i}, {63'd0, want.last});
        end
      end
      if (pkt_valid_i && pkt_ready_i) reorder_packet(pkt_data_i);
      if (cfg_we_i) window = cfg_wdata_i;
    end
    pending_o  = due_results.size();
    mismatch_o = mismatches;
  end

endmodule

>>> test/selective_repeat_receiver_tb.sv
// Top of the selective-repeat receiver bench: clock, reset, packet stimulus, window writes.
// Instantiates the receiver and srr_delivery_checker; depends on srr_pkg.
module selective_repeat_receiver_tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;

  typedef enum int {
    NOISE_BAD_SUM,
    NOISE_STRAY_SEQ,
    NOISE_REPEAT
  } noise_e;

  logic                      clk_i     = 1'b0;
  logic                      rst_ni    = 1'b0;
  logic                      cfg_we    = 1'b0;
  logic [srr_pkg::WIN_W-1:0] cfg_wdata = '0;
  logic                      pkt_valid = 1'b0;
  logic                      pkt_ready;
  logic [255:0]              pkt_data  = '0;
  logic                      res_valid;
  logic                      res_ready = 1'b0;
  logic [223:0]              res_data;
  logic [0:0]                res_kind;
  logic                      res_last;
  int                        mismatches;
  int                        pending;

  int          src_idle_pct = 0;
  int          dst_idle_pct = 0;
  int          items_sent   = 0;
  int          quiet_cycles = 0;
  logic [31:0] next_base    = 32'd0;
  logic [255:0] word;

  always #5 clk_i = ~clk_i;

  selective_repeat_receiver u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (pkt_valid),
    .s_axis_tready_o (pkt_ready),
    .s_axis_tdata_i  (pkt_data),
    .m_axis_tvalid_o (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (res_data),
    .m_axis_tuser_o  (res_kind),
    .m_axis_tlast_o  (res_last)
  );

  srr_delivery_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .pkt_valid_i (pkt_valid),
    .pkt_ready_i (pkt_ready),
    .pkt_data_i  (pkt_data),
    .res_valid_i (res_valid),
    .res_ready_i (res_ready),
    .res_data_i  (res_data),
    .res_kind_i  (res_kind),
    .res_last_i  (res_last),
    .mismatch_o  (mismatches),
    .pending_o   (pending)
  );

  always @(negedge clk_i) res_ready <= ($urandom_range(99) >= dst_idle_pct);

  always @(posedge clk_i) begin
    if (!rst_ni || (pkt_valid && pkt_ready) || (res_valid && res_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [255:0] build_packet(logic [31:0] seq, logic [31:0] ackn,
                                                logic [63:0] lo, logic [63:0] mid,
                                                logic [31:0] hi, bit good);
    logic [31:0] csum, delta;
    csum = seq + ackn;
    for (int k = 0; k < 8; k++) begin
      csum = csum + {{24{lo[8*k+7]}}, lo[8*k +: 8]};
      csum = csum + {{24{mid[8*k+7]}}, mid[8*k +: 8]};
    end
    for (int k = 0; k < 4; k++) csum = csum + {{24{hi[8*k+7]}}, hi[8*k +: 8]};
    if (!good) begin
      delta = $urandom;
      if (delta == 32'd0) delta = 32'd1;
      csum = csum + delta;
    end
    return {hi, mid, lo, csum, ackn, seq};
  endfunction

  // entered and left just after a falling edge
  task automatic push_packet(input logic [255:0] w);
    while ($urandom_range(99) < src_idle_pct) begin
      pkt_valid <= 1'b0;
      @(negedge clk_i);
    end
    pkt_valid <= 1'b1;
    pkt_data  <= w;
    @(posedge clk_i);
    while (!pkt_ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_packet(input logic [31:0] seq, input bit good);
    push_packet(build_packet(seq, $urandom, rand64(), rand64(), $urandom, good));
  endtask

  // new window only once the block has gone idle
  task automatic set_window(input logic [srr_pkg::WIN_W-1:0] wval);
    pkt_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= wval;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // sends next_base .. next_base+n-1 in some order, with noise mixed in
  task automatic run_burst(input int n, input int eff, input bit reversed);
    logic [31:0] order[$];
    logic [31:0] sent[$];
    logic [31:0] tmp;
    int          j;
    noise_e      noise;
    for (int i = 0; i < n; i++) order.insert(order.size(), next_base + 32'(i));
    if (reversed) begin
      order.reverse();
    end else if (eff >= 2) begin
      for (int i = n - 1; i > 0; i--) begin
        j        = $urandom_range(i, 0);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end
    foreach (order[i]) begin
      if ($urandom_range(99) < 15) begin
        noise = noise_e'($urandom_range(2, 0));
        case (noise)
          NOISE_BAD_SUM: begin
            send_packet(($urandom_range(1) == 1) ? order[i] : $urandom, 1'b0);
          end
          NOISE_STRAY_SEQ: begin
            send_packet($urandom, 1'b1);
          end
          NOISE_REPEAT: begin
            if (sent.size() > 0) send_packet(sent[$urandom_range(sent.size() - 1, 0)], 1'b1);
            else send_packet(order[i], 1'b0);
          end
          default: ;
        endcase
      end
      send_packet(order[i], 1'b1);
      sent.insert(sent.size(), order[i]);
    end
    next_base = next_base + n;
  endtask

  task automatic run_segment(input logic [srr_pkg::WIN_W-1:0] wval, input int count);
    int eff;
    int goal;
    set_window(wval);
    eff  = (wval > srr_pkg::WINDOW_MAX) ? srr_pkg::WINDOW_MAX : wval;
    goal = items_sent + count;
    // full window stored backward, then the base packet: longest drain
    if (eff == srr_pkg::WINDOW_MAX) run_burst(eff, eff, 1'b1);
    while (items_sent < goal) begin
      if (eff >= 2) run_burst($urandom_range(eff, 1), eff, $urandom_range(9, 0) == 0);
      else run_burst($urandom_range(4, 1), eff, 1'b0);
    end
  endtask

  initial begin
    src_idle_pct = 7;
    dst_idle_pct = 83;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // window at its reset value of 8
    push_packet(build_packet(32'd0, 32'd0, 64'd0, 64'd0, 32'd0, 1'b1));
    push_packet(build_packet(32'd1, 32'd0, 64'd1, 64'd0, 32'd0, 1'b0));
    push_packet(build_packet(32'd1, 32'hFFFF_FFFF, {8{8'hFF}}, {8{8'hFF}}, {4{8'hFF}}, 1'b1));
    push_packet(build_packet(32'd3, $urandom, {8{8'h80}}, {8{8'h80}}, {4{8'h80}}, 1'b1));
    push_packet(build_packet(32'd9, $urandom, {8{8'h7F}}, {8{8'h7F}}, {4{8'h7F}}, 1'b1));
    send_packet(32'd10, 1'b1);         // one past the window edge
    push_packet(build_packet(32'hFFFF_FFFF, 32'd0, 64'd0, 64'd0, 32'd0, 1'b1));
    send_packet(32'd3, 1'b1);          // overwrites the stored copy
    send_packet(32'd2, 1'b1);
    for (int s = 8; s >= 5; s--) send_packet(s, 1'b1);
    send_packet(32'd4, 1'b1);
    send_packet(32'd0, 1'b1);          // already delivered
    word        = build_packet(32'd5, 32'd0, 64'd0, 64'd0, 32'd0, 1'b1);
    word[95:64] = 32'hFFFF_FFFF;
    push_packet(word);
    // zero window: nothing is held, only in-order packets get through
    set_window('0);
    send_packet(32'd11, 1'b1);
    send_packet(32'd10, 1'b1);
    send_packet(32'd11, 1'b1);
    next_base = 32'd12;

    run_segment(6'd32, 35);
    run_segment(6'd5, 35);
    run_segment(6'd0, 30);

    src_idle_pct = 83;
    dst_idle_pct = 7;
    run_segment(6'd63, 35);
    run_segment(6'd1, 30);
    run_segment(6'd17, 35);

    src_idle_pct = 0;
    dst_idle_pct = 0;
    run_segment(6'd32, 35);
    run_segment(6'd2, 30);
    run_segment(6'd8, 35);

    pkt_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

>>> selective_repeat_receiver.f
+incdir+sv
sv/srr_pkg.sv
sv/srr_cell.sv
sv/srr_ctrl.sv
sv/selective_repeat_receiver.sv
test/srr_delivery_checker.sv
test/selective_repeat_receiver_tb.sv
